FILE: rtl/nps_pkg.sv
// shared types, codes and helpers for the nearest point select and move block
// no dependencies
`default_nettype none

package nps_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_W = 12;
  localparam int FUNC_W = 3;
  localparam int CLICK_W = 10;
  localparam int WH_W = 10;
  localparam logic [WH_W-1:0] WH_RESET = 10'd500;

  localparam logic signed [COORD_W:0] STEP = 13'sd5;
  localparam logic signed [COORD_W:0] COORD_MAX = 13'sd2047;
  localparam logic signed [COORD_W:0] COORD_MIN = -13'sd2048;

  localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SELECT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_UP = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DOWN = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LEFT = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_RIGHT = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CLICK_W-1:0] click_x;
    logic [CLICK_W-1:0] click_y;
  } in_t;

  typedef struct packed {
    logic selected_valid;
    logic [5:0] selected_index;
    logic signed [COORD_W-1:0] selected_x;
    logic signed [COORD_W-1:0] selected_y;
    logic [6:0] point_count;
    logic dropped;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MOVE,
    S_FETCH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic add_item;
    logic scan_start;
    logic scan_run;
    logic scan_commit;
    logic do_move;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic empty;
    logic chosen_valid;
    logic scan_done;
    logic out_free;
  } status_t;

  function automatic logic signed [COORD_W-1:0] sat_step(
    input logic signed [COORD_W-1:0] v,
    input logic down
  );
    logic signed [COORD_W:0] s;
    s = $signed({v[COORD_W-1], v}) + (down ? -STEP : STEP);
    if (s > COORD_MAX) begin
      return COORD_MAX[COORD_W-1:0];
    end else if (s < COORD_MIN) begin
      return COORD_MIN[COORD_W-1:0];
    end else begin
      return s[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nearest_point_select_move.sv
// Nearest point select and move: keeps up to MAX_POINTS points in a single-port-write,
// registered-read memory. Each item gives one result beat. An accepted item enters the exec
// state; add and unused codes, a select with no points and a move with nothing selected go
// on to fetch, a move first writes its stepped point back in the move state, and a select
// walks the stored points one memory read per cycle through a two-stage squared-distance
// pipeline in the scan state. Fetch reads the chosen point and out loads the result; the next
// item is taken in the cycle after, and a stalled result holds off the input until taken.
`default_nettype none

module nearest_point_select_move #(
  parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire nps_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output nps_pkg::out_t                   out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [nps_pkg::WH_W-1:0]   cfg_data
);

  nps_pkg::cmd_t cmd;
  nps_pkg::status_t status;

  assign cfg_ready = 1'b1;

  nps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  nps_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

FILE: rtl/nps_ctrl.sv
// controller state machine sequencing add, nearest scan, move and result beats
// depends on nps_pkg
`default_nettype none

module nps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire nps_pkg::status_t status,
  output nps_pkg::cmd_t         cmd
);

  nps_pkg::state_t state;
  nps_pkg::state_t state_next;
  logic is_move;

  assign is_move = (status.func == nps_pkg::FUNC_UP) || (status.func == nps_pkg::FUNC_DOWN) ||
                   (status.func == nps_pkg::FUNC_LEFT) || (status.func == nps_pkg::FUNC_RIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nps_pkg::S_IDLE: begin
        if (in_valid) state_next = nps_pkg::S_EXEC;
      end
      nps_pkg::S_EXEC: begin
        priority if (status.func == nps_pkg::FUNC_SELECT && !status.empty) begin
          state_next = nps_pkg::S_SCAN;
        end else if (is_move && status.chosen_valid) begin
          state_next = nps_pkg::S_MOVE;
        end else begin
          state_next = nps_pkg::S_FETCH;
        end
      end
      nps_pkg::S_SCAN: begin
        if (status.scan_done) state_next = nps_pkg::S_FETCH;
      end
      nps_pkg::S_MOVE: state_next = nps_pkg::S_FETCH;
      nps_pkg::S_FETCH: state_next = nps_pkg::S_OUT;
      nps_pkg::S_OUT: begin
        if (status.out_free) state_next = nps_pkg::S_IDLE;
      end
      default: state_next = nps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != nps_pkg::S_IDLE);
    cmd = '0;
    unique case (state)
      nps_pkg::S_IDLE: cmd.load_item = in_valid;
      nps_pkg::S_EXEC: begin
        cmd.add_item = (status.func == nps_pkg::FUNC_ADD);
        cmd.scan_start = (status.func == nps_pkg::FUNC_SELECT) && !status.empty;
      end
      nps_pkg::S_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.scan_commit = status.scan_done;
      end
      nps_pkg::S_MOVE: cmd.do_move = 1'b1;
      nps_pkg::S_FETCH: ;
      nps_pkg::S_OUT: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/nps_dpath.sv
// datapath: point memory, count and selection registers, distance pipeline,
// move arithmetic and result register; depends on nps_pkg
`default_nettype none

module nps_dpath #(
  parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire nps_pkg::in_t                  in_data,
  input  wire logic                          cfg_valid,
  input  wire logic [nps_pkg::WH_W-1:0]      cfg_data,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output nps_pkg::out_t                      out_data,
  input  wire nps_pkg::cmd_t                 cmd,
  output nps_pkg::status_t                   status
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW = nps_pkg::COORD_W;
  localparam int DIST_W = 2 * CW + 1;

  logic [2*CW-1:0] mem [MAX_POINTS];
  logic [2*CW-1:0] rdata;
  logic [IDX_W-1:0] rd_addr;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [2*CW-1:0] wr_data;

  logic [nps_pkg::WH_W-1:0] window_height;
  logic [nps_pkg::FUNC_W-1:0] item_func;
  logic signed [CW-1:0] item_x;
  logic signed [CW-1:0] item_y;
  logic dropped;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] chosen_index;
  logic chosen_valid;
  logic full;

  logic [CNT_W-1:0] scan_addr;
  logic scan_issue;
  logic v1;
  logic v2;
  logic [IDX_W-1:0] idx1;
  logic [IDX_W-1:0] idx2;
  logic [2*CW-1:0] sq_x;
  logic [2*CW-1:0] sq_y;
  logic [DIST_W-1:0] best;
  logic [IDX_W-1:0] best_i;
  logic found;

  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic signed [2*CW+1:0] dx_sq;
  logic signed [2*CW+1:0] dy_sq;
  logic [DIST_W-1:0] cand_dist;
  logic signed [CW-1:0] mx;
  logic signed [CW-1:0] my;

  assign px = rdata[2*CW-1:CW];
  assign py = rdata[CW-1:0];
  assign full = (count == CNT_W'(MAX_POINTS));
  assign scan_issue = cmd.scan_run && (scan_addr < count);
  assign rd_addr = cmd.scan_run ? scan_addr[IDX_W-1:0] : chosen_index;

  always_comb begin
    mx = px;
    my = py;
    unique case (item_func)
      nps_pkg::FUNC_UP: my = nps_pkg::sat_step(py, 1'b0);
      nps_pkg::FUNC_DOWN: my = nps_pkg::sat_step(py, 1'b1);
      nps_pkg::FUNC_LEFT: mx = nps_pkg::sat_step(px, 1'b1);
      nps_pkg::FUNC_RIGHT: mx = nps_pkg::sat_step(px, 1'b0);
      default: ;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = chosen_index;
    wr_data = {mx, my};
    if (cmd.add_item && !full) begin
      wr_en = 1'b1;
      wr_addr = count[IDX_W-1:0];
      wr_data = {item_x, item_y};
    end else if (cmd.do_move) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  assign dx = $signed({item_x[CW-1], item_x}) - $signed({px[CW-1], px});
  assign dy = $signed({item_y[CW-1], item_y}) - $signed({py[CW-1], py});
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign cand_dist = DIST_W'(sq_x) + DIST_W'(sq_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_height <= nps_pkg::WH_RESET;
      count <= '0;
      chosen_index <= '0;
      chosen_valid <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) window_height <= cfg_data;
      if (cmd.add_item && !full) count <= count + CNT_W'(1);
      v1 <= scan_issue;
      v2 <= v1;
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (v2 && (!found || cand_dist < best)) begin
        found <= 1'b1;
      end
      if (cmd.scan_commit && found) begin
        chosen_index <= best_i;
        chosen_valid <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func <= in_data.func;
      item_x <= CW'({2'b00, in_data.click_x});
      item_y <= CW'({2'b00, window_height}) - CW'({2'b00, in_data.click_y});
      dropped <= 1'b0;
    end else if (cmd.add_item && full) begin
      dropped <= 1'b1;
    end
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (scan_issue) begin
      scan_addr <= scan_addr + CNT_W'(1);
    end
    idx1 <= scan_addr[IDX_W-1:0];
    idx2 <= idx1;
    sq_x <= dx_sq[2*CW-1:0];
    sq_y <= dy_sq[2*CW-1:0];
    if (v2 && (!found || cand_dist < best)) begin
      best <= cand_dist;
      best_i <= idx2;
    end
    if (cmd.out_load) begin
      out_data.selected_valid <= chosen_valid;
      out_data.selected_index <= chosen_valid ? 6'(chosen_index) : 6'd0;
      out_data.selected_x <= chosen_valid ? px : '0;
      out_data.selected_y <= chosen_valid ? py : '0;
      out_data.point_count <= 7'(count);
      out_data.dropped <= dropped;
    end
  end

  assign status.func = item_func;
  assign status.empty = (count == '0);
  assign status.chosen_valid = chosen_valid;
  assign status.scan_done = (scan_addr == count) && !v1 && !v2;
  assign status.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire
